@@ src/blo_pkg.sv @@
// Shared types and codes for the bounded ordered list.
package blo_pkg;

    // Stream widths: fields packed from bit 0 up, padded to whole bytes
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 48;

    // Operation codes on the input stream
    localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
    localparam logic [2:0] OP_INSERT_POS = 3'd1;
    localparam logic [2:0] OP_APPEND     = 3'd2;
    localparam logic [2:0] OP_POP_FRONT  = 3'd3;
    localparam logic [2:0] OP_POP_BACK   = 3'd4;
    localparam logic [2:0] OP_REMOVE_POS = 3'd5;
    localparam logic [2:0] OP_DUMP       = 3'd6;
    localparam logic [2:0] OP_SEARCH     = 3'd7;

    // Status codes on the output stream
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_FULL     = 3'd1;
    localparam logic [2:0] ST_EMPTY    = 3'd2;
    localparam logic [2:0] ST_BADPOS   = 3'd3;
    localparam logic [2:0] ST_NOTFOUND = 3'd4;

    // Command class decided by the front end
    typedef enum logic [1:0] {
        CMD_INSERT,
        CMD_REMOVE,
        CMD_DUMP,
        CMD_SEARCH
    } cmd_kind_t;

    // Where an insert or remove acts
    typedef enum logic [1:0] {
        AT_FRONT,
        AT_POS,
        AT_BACK
    } cmd_where_t;

    typedef struct packed {
        cmd_kind_t         kind;
        cmd_where_t        where;
        logic signed [31:0] value;
        logic [2:0]        position;
    } cmd_t;

endpackage

@@ src/blo_front.sv @@
// Front end: accepts input transfers, decodes them and queues commands.
module blo_front (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // tdata: op[2:0], value[34:3], position[37:35], zero pad
    input  logic [blo_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                            cmd_valid,
    output blo_pkg::cmd_t                   cmd,
    input  logic                            cmd_pop
);
    import blo_pkg::*;

    cmd_t       q_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic [2:0] op;
    logic       push;
    logic       pop;
    cmd_t       dec;

    assign op = s_axis_tdata[2:0];

    // Classify the operation
    always_comb
    begin
        dec.value    = s_axis_tdata[34:3];
        dec.position = s_axis_tdata[37:35];
        unique case (op)
            OP_PUSH_FRONT: begin dec.kind = CMD_INSERT; dec.where = AT_FRONT; end
            OP_INSERT_POS: begin dec.kind = CMD_INSERT; dec.where = AT_POS;   end
            OP_APPEND:     begin dec.kind = CMD_INSERT; dec.where = AT_BACK;  end
            OP_POP_FRONT:  begin dec.kind = CMD_REMOVE; dec.where = AT_FRONT; end
            OP_POP_BACK:   begin dec.kind = CMD_REMOVE; dec.where = AT_BACK;  end
            OP_REMOVE_POS: begin dec.kind = CMD_REMOVE; dec.where = AT_POS;   end
            OP_DUMP:       begin dec.kind = CMD_DUMP;   dec.where = AT_FRONT; end
            OP_SEARCH:     begin dec.kind = CMD_SEARCH; dec.where = AT_FRONT; end
        endcase
    end

    // Two-entry command queue
    assign s_axis_tready = (cnt_reg != 2'd2);
    assign push          = s_axis_tvalid && s_axis_tready;
    assign cmd_valid     = (cnt_reg != 2'd0);
    assign pop           = cmd_pop && cmd_valid;
    assign cmd           = q_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push && !pop)
            cnt_next = cnt_reg + 2'd1;
        else if (pop && !push)
            cnt_next = cnt_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Queue payload
    always_ff @(posedge clk)
    begin
        if (push)
            q_reg[wr_ptr_reg] <= dec;
    end

endmodule

@@ src/blo_back.sv @@
// Back end: holds the list, executes commands and drives the result stream.
module blo_back #(
    parameter int DEPTH = 4
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cmd_valid,
    input  blo_pkg::cmd_t                   cmd,
    output logic                            cmd_pop,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // tdata: status[2:0], entry_value[34:3], entry_position[37:35],
    //        fill[40:38], zero pad
    output logic [blo_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    output logic                            m_axis_tlast
);
    import blo_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);
    localparam int WW = CW + 3;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DUMP,
        S_SEARCH,
        S_REPORT
    } state_t;

    typedef enum logic [1:0] {
        ENT_HOLD,
        ENT_INSERT,
        ENT_REMOVE,
        ENT_ROTATE
    } ent_op_t;

    state_t             state_reg, state_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [CW-1:0]      scan_reg, scan_next;
    logic               found_reg, found_next;
    logic [2:0]         hit_reg, hit_next;
    logic signed [31:0] key_reg, key_next;

    logic               out_valid_reg, out_valid_next;
    logic [2:0]         status_reg, status_next;
    logic signed [31:0] value_reg, value_next;
    logic [2:0]         pos_reg, pos_next;
    logic [2:0]         fill_reg, fill_next;
    logic               last_reg, last_next;

    logic signed [31:0] ent_reg  [DEPTH];
    logic signed [31:0] ent_next [DEPTH];
    ent_op_t            ent_op;
    logic [CW-1:0]      idx;
    logic [CW-1:0]      rem_idx;
    logic signed [31:0] rem_val;

    logic               out_free;
    logic [WW-1:0]      pos_ext;
    logic [WW-1:0]      cnt_ext;
    logic               scan_end;
    logic               scan_live;

    assign out_free  = !out_valid_reg || m_axis_tready;
    assign pos_ext   = WW'(cmd.position);
    assign cnt_ext   = WW'(count_reg);
    assign scan_end  = (scan_reg == CW'(DEPTH - 1));
    assign scan_live = (scan_reg < count_reg);

    // Slot a remove acts on, and the entry held there
    always_comb
    begin
        rem_idx = '0;
        if (cmd.where == AT_BACK)
            rem_idx = count_reg - CW'(1);
        else if (cmd.where == AT_POS)
            rem_idx = CW'(pos_ext - WW'(1));
        rem_val = '0;
        for (int i = 0; i < DEPTH; i++)
            rem_val = rem_val | (ent_reg[i] & {32{CW'(i) == rem_idx}});
    end

    // Command sequencing and result generation
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        scan_next      = scan_reg;
        found_next     = found_reg;
        hit_next       = hit_reg;
        key_next       = key_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        status_next    = status_reg;
        value_next     = value_reg;
        pos_next       = pos_reg;
        fill_next      = fill_reg;
        last_next      = last_reg;
        ent_op         = ENT_HOLD;
        idx            = '0;
        cmd_pop        = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid && out_free)
                begin
                    cmd_pop = 1'b1;
                    case (cmd.kind)
                        CMD_INSERT:
                        begin
                            out_valid_next = 1'b1;
                            value_next     = '0;
                            pos_next       = 3'd0;
                            last_next      = 1'b1;
                            fill_next      = 3'(count_reg);
                            if (count_reg == CW'(DEPTH))
                                status_next = ST_FULL;
                            else if (cmd.where == AT_POS && (pos_ext == '0 ||
                                     pos_ext > cnt_ext + WW'(1)))
                                status_next = ST_BADPOS;
                            else
                            begin
                                status_next = ST_OK;
                                if (cmd.where == AT_BACK)
                                    idx = count_reg;
                                else if (cmd.where == AT_POS)
                                    idx = CW'(pos_ext - WW'(1));
                                ent_op     = ENT_INSERT;
                                count_next = count_reg + CW'(1);
                                fill_next  = 3'(count_reg + CW'(1));
                            end
                        end
                        CMD_REMOVE:
                        begin
                            out_valid_next = 1'b1;
                            value_next     = '0;
                            pos_next       = 3'd0;
                            last_next      = 1'b1;
                            fill_next      = 3'(count_reg);
                            if (count_reg == '0)
                                status_next = ST_EMPTY;
                            else if (cmd.where == AT_POS && (pos_ext == '0 ||
                                     pos_ext > cnt_ext))
                                status_next = ST_BADPOS;
                            else
                            begin
                                status_next = ST_OK;
                                idx        = rem_idx;
                                value_next = rem_val;
                                ent_op     = ENT_REMOVE;
                                count_next = count_reg - CW'(1);
                                fill_next  = 3'(count_reg - CW'(1));
                            end
                        end
                        CMD_DUMP:
                        begin
                            if (count_reg == '0)
                            begin
                                out_valid_next = 1'b1;
                                status_next    = ST_EMPTY;
                                value_next     = '0;
                                pos_next       = 3'd0;
                                fill_next      = 3'(count_reg);
                                last_next      = 1'b1;
                            end
                            else
                            begin
                                scan_next  = '0;
                                state_next = S_DUMP;
                            end
                        end
                        default:
                        begin
                            key_next   = cmd.value;
                            found_next = 1'b0;
                            hit_next   = 3'd0;
                            scan_next  = '0;
                            state_next = S_SEARCH;
                        end
                    endcase
                end
            end

            // Rotate the list once around, sending each live head entry
            S_DUMP:
            begin
                if (!scan_live || out_free)
                begin
                    if (scan_live)
                    begin
                        out_valid_next = 1'b1;
                        status_next    = ST_OK;
                        value_next     = ent_reg[0];
                        pos_next       = 3'(scan_reg + CW'(1));
                        fill_next      = 3'(count_reg);
                        last_next      = (scan_reg + CW'(1) == count_reg);
                    end
                    ent_op = ENT_ROTATE;
                    if (scan_end)
                        state_next = S_IDLE;
                    else
                        scan_next = scan_reg + CW'(1);
                end
            end

            // Rotate once around, noting the first live match
            S_SEARCH:
            begin
                ent_op = ENT_ROTATE;
                if (!found_reg && scan_live && ent_reg[0] == key_reg)
                begin
                    found_next = 1'b1;
                    hit_next   = 3'(scan_reg + CW'(1));
                end
                if (scan_end)
                    state_next = S_REPORT;
                else
                    scan_next = scan_reg + CW'(1);
            end

            S_REPORT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    status_next    = found_reg ? ST_OK : ST_NOTFOUND;
                    value_next     = '0;
                    pos_next       = found_reg ? hit_reg : 3'd0;
                    fill_next      = 3'(count_reg);
                    last_next      = 1'b1;
                    state_next     = S_IDLE;
                end
            end
        endcase
    end

    // Shift and rotate network over the entry registers
    always_comb
    begin
        ent_next = ent_reg;
        case (ent_op)
            ENT_INSERT:
            begin
                if (idx == '0)
                    ent_next[0] = cmd.value;
                for (int i = 1; i < DEPTH; i++)
                begin
                    if (CW'(i) == idx)
                        ent_next[i] = cmd.value;
                    else if (CW'(i) > idx)
                        ent_next[i] = ent_reg[i - 1];
                end
            end
            ENT_REMOVE:
            begin
                for (int i = 0; i < DEPTH - 1; i++)
                begin
                    if (CW'(i) >= idx)
                        ent_next[i] = ent_reg[i + 1];
                end
            end
            ENT_ROTATE:
            begin
                for (int i = 0; i < DEPTH - 1; i++)
                    ent_next[i] = ent_reg[i + 1];
                ent_next[DEPTH - 1] = ent_reg[0];
            end
            default:
            begin
                ent_next = ent_reg;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            scan_reg      <= '0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            scan_reg      <= scan_next;
            found_reg     <= found_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        hit_reg    <= hit_next;
        key_reg    <= key_next;
        status_reg <= status_next;
        value_reg  <= value_next;
        pos_reg    <= pos_next;
        fill_reg   <= fill_next;
        last_reg   <= last_next;
        ent_reg    <= ent_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tlast  = last_reg;
    assign m_axis_tdata  = {7'd0, fill_reg, pos_reg, value_reg, status_reg};

endmodule

@@ src/bounded_ordered_list.sv @@
// Bounded ordered list: top level joining the command front end and the list back end.
//
// Keeps up to DEPTH signed 32-bit entries with 1-based positions. Each input
// transfer carries one operation; each gives one result transfer, except a dump
// of a non-empty list, which gives one per entry from the front with tlast on
// the final one. A two-entry command queue sits between input and execution, so
// input transfers are taken while the back end works or the output stalls,
// until both entries are full. Inserts and removes are carried out from the
// idle state; a dump and a search walk the list by rotating the entry
// registers once around through the head slot, and a dump waits on output
// stalls. fill and entry_position are reported modulo 8.
module bounded_ordered_list #(
    parameter int DEPTH = 4
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // tdata: op[2:0], value[34:3], position[37:35], zero pad
    input  logic [blo_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // tdata: status[2:0], entry_value[34:3], entry_position[37:35],
    //        fill[40:38], zero pad
    output logic [blo_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    output logic                            m_axis_tlast
);
    import blo_pkg::*;

    logic cmd_valid;
    logic cmd_pop;
    cmd_t cmd;

    blo_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .cmd_valid     (cmd_valid),
        .cmd           (cmd),
        .cmd_pop       (cmd_pop)
    );

    blo_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd_valid     (cmd_valid),
        .cmd           (cmd),
        .cmd_pop       (cmd_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule
